FILE: design/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared constants, codes and types of the DMX512 frame receiver.
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int CHANNELS     = 512;
    localparam int PACKET_SLOTS = 513;

    // field widths of the channels
    localparam int CMD_W     = 3;
    localparam int DATA_W    = 8;
    localparam int CHAN_W    = 9;
    localparam int PUB_LEN_W = 10;

    // internal widths
    localparam int CNT_W   = $clog2(PACKET_SLOTS + 1);
    localparam int LEN_W   = $clog2(CHANNELS + 1);
    localparam int STG_AW  = $clog2(PACKET_SLOTS);
    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PEND_AW = CH_AW + 1;

    // frame RAM: both pending banks at the bottom, staging slots above them
    localparam int STG_BASE  = 2 ** PEND_AW;
    localparam int FRM_DEPTH = STG_BASE + PACKET_SLOTS;
    localparam int FRM_AW    = $clog2(FRM_DEPTH);

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_START_CODE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE    = 3'd0,
        CMD_FRAMING = 3'd1,
        CMD_OVERRUN = 3'd2,
        CMD_IDLE    = 3'd3,
        CMD_LATCH   = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 frame_ready;
        logic [PUB_LEN_W-1:0] published_len;
        logic [DATA_W-1:0]    read_value;
        logic                 receiving;
    } t_result;

endpackage

FILE: design/dmx_in_if.sv
// ----------------------------------------------------------------------------
// dmx_in_if
// Line event channel: valid/ready handshake with command, data and channel.
// ----------------------------------------------------------------------------
interface dmx_in_if
    import dmx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    logic [CHAN_W-1:0] channel;

    modport source (output valid, output cmd, output data, output channel, input ready);
    modport sink   (input valid, input cmd, input data, input channel, output ready);
endinterface

FILE: design/dmx_out_if.sv
// ----------------------------------------------------------------------------
// dmx_out_if
// Result channel: valid/ready handshake with the per-event status fields.
// ----------------------------------------------------------------------------
interface dmx_out_if
    import dmx_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 frame_ready;
    logic [PUB_LEN_W-1:0] published_len;
    logic [DATA_W-1:0]    read_value;
    logic                 receiving;

    modport source (output valid, output frame_ready, output published_len,
                    output read_value, output receiving, input ready);
    modport sink   (input valid, input frame_ready, input published_len,
                    input read_value, input receiving, output ready);
endinterface

FILE: design/dmx_ram.sv
// ----------------------------------------------------------------------------
// dmx_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/dmx512_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// dmx512_frame_receiver_unit
// DMX512 receiver: stages line bytes, publishes packets into two pending
// banks and latches a bank into the active channel store.
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// i_in      sink       valid/ready       cmd, data, channel
// o_out     source     valid/ready       frame_ready, published_len, read_value,
//                                        receiving
// apb       slave      psel/penable      paddr, pwdata, prdata (pready tied high)
//
// byte, overrun, framing error or idle line without publish, empty latch: from idle straight to done
// read channel: below the fill mark through the read state (active store read), else to done
// publish and non-empty latch: copy state, one slot per cycle through the RAM ports
// active store reads as zero above a fill mark, so reset needs no clearing pass
// a result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module dmx512_frame_receiver_unit
    import dmx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dmx_in_if.sink            i_in,
    dmx_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    // control state
    t_state             r_state, n_state;
    logic               r_in_recv, n_in_recv;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_wbank, n_wbank;
    logic [LEN_W-1:0]   r_plen [2];
    logic [LEN_W-1:0]   n_plen [2];
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic               r_wv, n_wv;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_cfg_start;

    // payload state
    logic [DATA_W-1:0]  r_start_byte, n_start_byte;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CH_AW-1:0]   r_widx, n_widx;
    logic               r_is_pub, n_is_pub;
    t_result            r_res, n_res;
    t_result            r_out, n_out;

    // memory ports
    logic               stg_we;
    logic [STG_AW-1:0]  stg_waddr, stg_raddr;
    logic               pend_we;
    logic [PEND_AW-1:0] pend_waddr, pend_raddr;
    logic               frm_we;
    logic [FRM_AW-1:0]  frm_waddr, frm_raddr;
    logic [DATA_W-1:0]  frm_wdata, frm_rdata;
    logic               act_we;
    logic [CH_AW-1:0]   act_raddr;
    logic [DATA_W-1:0]  act_rdata;

    logic               accept;
    logic               issue;
    logic               pub_ok;
    logic [LEN_W-1:0]   pub_len;
    logic [LEN_W-1:0]   latch_len;
    logic [PUB_LEN_W-1:0] res_len;
    logic               cfg_wr;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_START_CODE) ? APB_DW'(r_cfg_start) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= '0;
        end else if (cfg_wr && paddr[2] == REG_START_CODE) begin
            r_cfg_start <= pwdata[DATA_W-1:0];
        end
    end

    // publish needs two staged bytes and a matching start code
    assign pub_ok  = (int'(r_count) >= 2) && (r_start_byte == r_cfg_start);
    assign pub_len = ((int'(r_count) - 1) > CHANNELS) ? LEN_W'(CHANNELS)
                                                       : LEN_W'(int'(r_count) - 1);
    assign latch_len = r_plen[~r_wbank];
    assign res_len   = PUB_LEN_W'(pub_len);

    // copy engine addresses
    assign issue      = (r_idx < r_len);
    assign stg_raddr  = STG_AW'(r_idx + LEN_W'(1));
    assign pend_raddr = {~r_wbank, r_idx[CH_AW-1:0]};
    assign pend_waddr = {r_wbank, r_widx};
    assign pend_we    = (r_state == ST_COPY) && r_wv && r_is_pub;
    assign act_we     = (r_state == ST_COPY) && r_wv && !r_is_pub;
    assign act_raddr  = i_in.channel[CH_AW-1:0];
    assign stg_waddr  = r_count[STG_AW-1:0];
    assign stg_we     = accept && (t_cmd'(i_in.cmd) == CMD_BYTE)
                        && (int'(r_count) < PACKET_SLOTS);

    // staging and pending share one RAM: bytes land only in idle, bank writes only in copy
    assign frm_we    = stg_we || pend_we;
    assign frm_waddr = pend_we ? FRM_AW'(pend_waddr)
                               : FRM_AW'(STG_BASE) + FRM_AW'(stg_waddr);
    assign frm_wdata = pend_we ? frm_rdata : i_in.data;
    assign frm_raddr = r_is_pub ? FRM_AW'(STG_BASE) + FRM_AW'(stg_raddr)
                                : FRM_AW'(pend_raddr);

    always_comb begin
        n_state      = r_state;
        n_in_recv    = r_in_recv;
        n_count      = r_count;
        n_wbank      = r_wbank;
        n_plen       = r_plen;
        n_fill       = r_fill;
        n_wv         = 1'b0;
        n_out_valid  = r_out_valid;
        n_start_byte = r_start_byte;
        n_idx        = r_idx;
        n_len        = r_len;
        n_widx       = r_widx;
        n_is_pub     = r_is_pub;
        n_res        = r_res;
        n_out        = r_out;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_idx   = '0;
                    n_state = ST_DONE;
                    unique case (t_cmd'(i_in.cmd))
                        CMD_BYTE: begin
                            if (int'(r_count) < PACKET_SLOTS) begin
                                n_count = r_count + CNT_W'(1);
                                if (r_count == '0) begin
                                    n_start_byte = i_in.data;
                                end
                            end
                        end
                        CMD_FRAMING: begin
                            if (i_in.data == '0) begin
                                // break: publish what is staged, start a new packet
                                if (r_in_recv && pub_ok) begin
                                    n_res.frame_ready   = 1'b1;
                                    n_res.published_len = res_len;
                                    n_len               = pub_len;
                                    n_is_pub            = 1'b1;
                                    n_state             = ST_COPY;
                                end
                                n_count   = '0;
                                n_in_recv = 1'b1;
                            end else if (r_in_recv) begin
                                // corrupt byte: salvage what is staged
                                if (pub_ok) begin
                                    n_res.frame_ready   = 1'b1;
                                    n_res.published_len = res_len;
                                    n_len               = pub_len;
                                    n_is_pub            = 1'b1;
                                    n_state             = ST_COPY;
                                end
                                n_count   = '0;
                                n_in_recv = 1'b0;
                            end
                        end
                        CMD_OVERRUN: begin
                            n_count   = '0;
                            n_in_recv = 1'b0;
                        end
                        CMD_IDLE: begin
                            if (r_in_recv && r_count != '0) begin
                                if (pub_ok) begin
                                    n_res.frame_ready   = 1'b1;
                                    n_res.published_len = res_len;
                                    n_len               = pub_len;
                                    n_is_pub            = 1'b1;
                                    n_state             = ST_COPY;
                                end
                                n_in_recv = 1'b0;
                            end
                        end
                        CMD_LATCH: begin
                            if (latch_len != '0) begin
                                n_len    = latch_len;
                                n_is_pub = 1'b0;
                                n_state  = ST_COPY;
                                if (latch_len > r_fill) begin
                                    n_fill = latch_len;
                                end
                            end
                        end
                        CMD_READ: begin
                            if ((10'(i_in.channel) < 10'(CHANNELS))
                                && (10'(i_in.channel) < 10'(r_fill))) begin
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.receiving = n_in_recv;
                end
            end
            ST_COPY: begin
                // read slot r_idx, write it in the following cycle
                if (issue) begin
                    n_idx = r_idx + LEN_W'(1);
                end
                n_wv   = issue;
                n_widx = r_idx[CH_AW-1:0];
                if (!issue && !r_wv) begin
                    n_state = ST_DONE;
                    if (r_is_pub) begin
                        n_plen[r_wbank] = r_len;
                        n_wbank         = ~r_wbank;
                    end
                end
            end
            ST_READ: begin
                n_res.read_value = act_rdata;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_recv   <= 1'b0;
            r_count     <= '0;
            r_wbank     <= 1'b0;
            r_plen[0]   <= '0;
            r_plen[1]   <= '0;
            r_fill      <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_recv   <= n_in_recv;
            r_count     <= n_count;
            r_wbank     <= n_wbank;
            r_plen      <= n_plen;
            r_fill      <= n_fill;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_byte <= n_start_byte;
        r_idx        <= n_idx;
        r_len        <= n_len;
        r_widx       <= n_widx;
        r_is_pub     <= n_is_pub;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.frame_ready   = r_out.frame_ready;
    assign o_out.published_len = r_out.published_len;
    assign o_out.read_value    = r_out.read_value;
    assign o_out.receiving     = r_out.receiving;

    dmx_ram #(.WIDTH(DATA_W), .DEPTH(FRM_DEPTH)) u_frame (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (frm_waddr),
        .i_wdata (frm_wdata),
        .i_raddr (frm_raddr),
        .o_rdata (frm_rdata)
    );

    dmx_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_active (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (r_widx),
        .i_wdata (frm_rdata),
        .i_raddr (act_raddr),
        .o_rdata (act_rdata)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= PACKET_SLOTS)
        else $error("staged count beyond packet slots");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= CHANNELS)
        else $error("active fill mark beyond channel count");

    a_write_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_state == ST_COPY))
        else $error("copy write pending outside copy state");

    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wbank != $past(r_wbank)) |-> ($past(r_state) == ST_COPY && $past(r_is_pub)))
        else $error("write bank flipped outside a publish");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && issue) |=> (r_state == ST_COPY))
        else $error("copy left with slots outstanding");
endmodule

FILE: bench/dmx_status_checker.sv
// ----------------------------------------------------------------------------
// dmx_status_checker
// Watches the line event, status and register channels of the DMX512 frame
// receiver, predicts the status of every accepted event from its own copy
// of the staging, bank and active stores, and compares it field by field.
// ----------------------------------------------------------------------------
module dmx_status_checker
    import dmx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dmx_in_if                 i_in,
    dmx_out_if                i_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_published
);
    timeunit 1ns;
    timeprecision 1ps;

    // receiver state as the block should hold it
    logic [DATA_W-1:0] start_code;
    bit                rx_active;
    int unsigned       staged_n;
    logic [DATA_W-1:0] stage_mem [PACKET_SLOTS];
    logic [DATA_W-1:0] bank_mem [2][CHANNELS];
    int unsigned       bank_len [2];
    bit                wr_bank;
    logic [DATA_W-1:0] live_mem [CHANNELS];

    t_result expected_status [$];
    int      fails     = 0;
    int      checked   = 0;
    int      published = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_published  = 0;
    end

    function automatic void reset_model();
        start_code = '0;
        rx_active  = 1'b0;
        staged_n   = 0;
        bank_len   = '{0, 0};
        wr_bank    = 1'b0;
        foreach (live_mem[k]) live_mem[k] = '0;
    endfunction

    // copy the staged packet into the write bank, returns the channel count
    function automatic int unsigned publish_frame();
        int unsigned n;
        if (staged_n < 2 || stage_mem[0] != start_code)
            return 0;
        n = staged_n - 1;
        if (n > CHANNELS)
            n = CHANNELS;
        for (int k = 0; k < n; k++)
            bank_mem[wr_bank][k] = stage_mem[k + 1];
        bank_len[wr_bank] = n;
        wr_bank = ~wr_bank;
        return n;
    endfunction

    function automatic t_result next_status(t_cmd cmd, logic [DATA_W-1:0] data,
                                            logic [CHAN_W-1:0] chan);
        t_result     r;
        int unsigned n;
        bit          rb;
        r = '0;
        n = 0;
        case (cmd)
            CMD_BYTE: begin
                // bytes past the last slot are dropped
                if (staged_n < PACKET_SLOTS) begin
                    stage_mem[staged_n] = data;
                    staged_n++;
                end
            end
            CMD_FRAMING: begin
                if (data == '0) begin
                    if (rx_active && staged_n > 0)
                        n = publish_frame();
                    staged_n  = 0;
                    rx_active = 1'b1;
                end else if (rx_active) begin
                    // corrupt byte: salvage what was staged
                    if (staged_n >= 2)
                        n = publish_frame();
                    staged_n  = 0;
                    rx_active = 1'b0;
                end
            end
            CMD_OVERRUN: begin
                staged_n  = 0;
                rx_active = 1'b0;
            end
            CMD_IDLE: begin
                if (rx_active && staged_n > 0) begin
                    n = publish_frame();
                    rx_active = 1'b0;
                end
            end
            CMD_LATCH: begin
                rb = ~wr_bank;
                for (int k = 0; k < bank_len[rb]; k++)
                    live_mem[k] = bank_mem[rb][k];
            end
            CMD_READ: begin
                if (chan < CHANNELS)
                    r.read_value = live_mem[chan];
            end
            default: ;
        endcase
        r.frame_ready   = (n != 0);
        r.published_len = PUB_LEN_W'(n);
        r.receiving     = rx_active;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            reset_model();
            expected_status.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_START_CODE)
                start_code = pwdata[DATA_W-1:0];
            // compare before pushing so a status can never match its own event
            if (i_out.valid && i_out.ready) begin
                if (expected_status.size() == 0) begin
                    $error("status transaction with no event waiting for it");
                    fails++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("frame_ready", want.frame_ready, i_out.frame_ready);
                    check_field("published_len", want.published_len, i_out.published_len);
                    check_field("read_value", want.read_value, i_out.read_value);
                    check_field("receiving", want.receiving, i_out.receiving);
                    checked++;
                end
            end
            if (i_in.valid && i_in.ready) begin
                want = next_status(t_cmd'(i_in.cmd), i_in.data, i_in.channel);
                if (want.frame_ready)
                    published++;
                expected_status.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_status.size();
        o_checked    <= checked;
        o_published  <= published;
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives line events and start code writes into the DMX512 frame receiver:
// a directed opening, then random frames, latches and reads under changing
// back pressure, one long output stall and one over-length frame.
// ----------------------------------------------------------------------------
module tb_top;
    import dmx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int          fail_count;
    int          pending;
    int          checked;
    int          published;
    int          items_sent  = 0;
    int          frames_sent = 0;
    int          src_idle_pct  = 7;
    int          sink_idle_pct = 55;
    bit          hold_req = 1'b0;
    logic        stall_on = 1'b0;
    int unsigned cycles   = 0;
    logic [DATA_W-1:0] mid_code;

    dmx_in_if  in_ch ();
    dmx_out_if out_ch ();

    dmx512_frame_receiver_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dmx_status_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_published  (published)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // status receiver
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= !stall_on && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // long output stall so the block backs up into its input
    initial begin : long_hold
        wait (hold_req);
        @(posedge clk);
        stall_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_on <= 1'b0;
    end

    task automatic send_event(input t_cmd c, input logic [DATA_W-1:0] d,
                              input logic [CHAN_W-1:0] ch);
        int gap;
        if ($urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= c;
        in_ch.data    <= d;
        in_ch.channel <= ch;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_start_code(input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({REG_START_CODE, 2'b00});
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // break, start code, body, then one of the ways a frame can end
    task automatic send_frame(input logic [DATA_W-1:0] code, input int body_len,
                              input bit clean);
        int ending;
        send_event(CMD_FRAMING, '0, CHAN_W'($urandom));
        send_event(CMD_BYTE, (clean || $urandom_range(9) < 8) ? code : DATA_W'($urandom),
                   CHAN_W'($urandom));
        repeat (body_len) send_event(CMD_BYTE, DATA_W'($urandom), CHAN_W'($urandom));
        ending = clean ? 60 : $urandom_range(99);
        if (ending >= 55 && ending < 75)
            send_event(CMD_IDLE, DATA_W'($urandom), CHAN_W'($urandom));
        else if (ending >= 75 && ending < 88)
            send_event(CMD_FRAMING, DATA_W'($urandom_range(1, 255)), CHAN_W'($urandom));
        else if (ending >= 88)
            send_event(CMD_OVERRUN, DATA_W'($urandom), CHAN_W'($urandom));
        frames_sent++;
    endtask

    task automatic run_phase(input int item_goal, input logic [DATA_W-1:0] code,
                             input bit with_full);
        int pick;
        bit full_done;
        full_done = 1'b0;
        while (items_sent < item_goal) begin
            pick = $urandom_range(99);
            if (with_full && !full_done && items_sent >= item_goal - 560) begin
                // over-length frame: the last slots are dropped
                send_frame(code, PACKET_SLOTS + 2, 1'b1);
                full_done = 1'b1;
            end else if (pick < 10) begin
                send_event(t_cmd'($urandom_range(0, 5)), DATA_W'($urandom), CHAN_W'($urandom));
            end else if (pick < 25) begin
                send_event(CMD_LATCH, DATA_W'($urandom), CHAN_W'($urandom));
                repeat ($urandom_range(1, 4))
                    send_event(CMD_READ, DATA_W'($urandom),
                               ($urandom_range(3) == 0) ? CHAN_W'($urandom)
                                                        : CHAN_W'($urandom_range(0, 24)));
            end else begin
                send_frame(code, $urandom_range(0, 24), 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_BYTE;
        in_ch.data    <= '0;
        in_ch.channel <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, start code left at its reset value
        send_event(CMD_READ, 8'h00, 9'd0);
        send_event(CMD_IDLE, 8'h00, 9'd0);
        send_event(CMD_FRAMING, 8'hA5, 9'd0);   // corrupt byte while idle
        send_event(CMD_BYTE, 8'h00, 9'd0);      // staged although idle
        send_event(CMD_BYTE, 8'hFF, 9'd511);
        send_event(CMD_FRAMING, 8'h00, 9'd0);   // break while idle, no publish
        send_event(CMD_BYTE, 8'h00, 9'd0);
        send_event(CMD_BYTE, 8'hFF, 9'd0);
        send_event(CMD_BYTE, 8'h80, 9'd0);
        send_event(CMD_BYTE, 8'h01, 9'd0);
        send_event(CMD_FRAMING, 8'h00, 9'd0);   // publishes three channels
        send_event(CMD_BYTE, 8'h00, 9'd0);
        send_event(CMD_IDLE, 8'h00, 9'd0);      // start code only, nothing published
        send_event(CMD_LATCH, 8'h00, 9'd0);
        send_event(CMD_READ, 8'h00, 9'd0);
        send_event(CMD_READ, 8'h00, 9'd2);
        send_event(CMD_READ, 8'hFF, 9'd511);
        send_event(CMD_FRAMING, 8'h00, 9'd0);   // break while idle, no publish
        send_event(CMD_BYTE, 8'h00, 9'd0);
        send_event(CMD_BYTE, 8'h7E, 9'd0);
        send_event(CMD_FRAMING, 8'h5A, 9'd0);   // salvage two bytes, then idle
        send_event(CMD_FRAMING, 8'h00, 9'd0);
        send_event(CMD_BYTE, 8'h33, 9'd0);      // wrong start code
        send_event(CMD_BYTE, 8'h44, 9'd0);
        send_event(CMD_IDLE, 8'h00, 9'd0);
        send_event(CMD_OVERRUN, 8'h00, 9'd0);
        send_event(CMD_LATCH, 8'h00, 9'd0);
        drain_results();

        write_start_code(8'hFF);
        hold_req = 1'b1;
        run_phase(330, 8'hFF, 1'b0);
        drain_results();

        src_idle_pct  <= 55;
        sink_idle_pct <= 7;
        mid_code = DATA_W'($urandom_range(1, 254));
        write_start_code(mid_code);
        run_phase(630, mid_code, 1'b0);
        drain_results();

        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        write_start_code(8'h00);
        run_phase(1180, 8'h00, 1'b1);
        drain_results();

        $display("sent %0d line events in %0d frames under start codes 00, ff, %02h and 00",
                 items_sent, frames_sent, mid_code);
        $display("checked %0d status transactions, %0d packets published, one over-length",
                 checked, published);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
